// File: rtl/grq_pkg.sv
// Shared types, constants and a helper function for the graph reachability query block.
// It depends on nothing. The controller, the datapath and the top level all import it.
package grq_pkg;

	localparam int NODE_W = 32;
	localparam int IDX_W  = 5;
	localparam int CNT_W  = 6;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic accept;
		logic quick_out;
		logic init;
		logic step;
		logic finish_hit;
		logic finish_miss;
	} grq_cmd_t;

	typedef struct packed {
		logic quick;
		logic hit;
		logic empty;
	} grq_stat_t;

	// Returns the index of the lowest set bit. Returns zero for an empty vector.
	function automatic logic [IDX_W-1:0] lowest_set(input logic [NODE_W-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = NODE_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/grq_ctrl.sv
// Controller state machine for the graph reachability query block.
// It depends on grq_pkg and drives the datapath only through grq_cmd_t and grq_stat_t.
module grq_ctrl
	import grq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  grq_stat_t stat,
	output grq_cmd_t  cmd,
	output logic      busy
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_SEARCH = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept    = start;
				cmd.quick_out = start && stat.quick;
				cmd.init      = start && !stat.quick;
				if (start && !stat.quick) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				// An empty pending set means the target was never reached.
				priority if (stat.empty) begin
					cmd.finish_miss = 1'b1;
					state_d         = ST_IDLE;
				end else if (stat.hit) begin
					cmd.finish_hit = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q == ST_SEARCH);

endmodule

// File: rtl/grq_datapath.sv
// Datapath of the graph reachability query block: adjacency rows, search sets and result registers.
// It depends on grq_pkg and is driven by grq_ctrl through grq_cmd_t.
module grq_datapath
	import grq_pkg::*;
#(
	parameter int MAX_NODES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  grq_cmd_t          cmd,
	output grq_stat_t         stat,
	input  logic [CNT_W-1:0]  node_count,
	input  logic              operation,
	input  logic [IDX_W-1:0]  source_node,
	input  logic [IDX_W-1:0]  target_node,
	input  logic [NODE_W-1:0] row_bits,
	output logic              done,
	output logic              reachable,
	output logic              index_error
);

	localparam int ROWS  = (MAX_NODES < NODE_W) ? MAX_NODES : NODE_W;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [CNT_W:0] MAX_N = (CNT_W + 1)'(MAX_NODES);

	logic [NODE_W-1:0] rows_q [ROWS];
	logic [NODE_W-1:0] visited_q;
	logic [NODE_W-1:0] pending_q;
	logic [NODE_W-1:0] mask_q;
	logic [IDX_W-1:0]  dst_q;
	logic              done_q;
	logic              reach_q;
	logic              err_q;

	logic [CNT_W:0]    count_ext;
	logic [CNT_W:0]    live;
	logic [NODE_W-1:0] live_mask;
	logic              src_bad;
	logic              dst_bad;
	logic              quick_err;
	logic              quick_reach;
	logic              src_in_rows;
	logic [IDX_W-1:0]  cur;
	logic [NODE_W-1:0] cur_bit;
	logic [NODE_W-1:0] fresh;
	logic [NODE_W-1:0] src_bit;

	// A node count above the storage size saturates.
	assign count_ext = {1'b0, node_count};
	assign live      = (count_ext > MAX_N) ? MAX_N : count_ext;

	always_comb begin
		for (int i = 0; i < NODE_W; i++) begin
			live_mask[i] = ((CNT_W + 1)'(i) < live);
		end
	end

	assign src_bad     = ({2'b0, source_node} >= live);
	assign dst_bad     = ({2'b0, target_node} >= live);
	assign quick_err   = (operation == OP_WRITE) ? src_bad : (src_bad || dst_bad);
	assign quick_reach = (operation == OP_QUERY) && !quick_err && (source_node == target_node);
	assign src_in_rows = ({2'b0, source_node} < MAX_N);
	assign src_bit     = NODE_W'(1) << source_node;

	// One expansion a cycle: the lowest pending node, then its unvisited successors.
	assign cur     = lowest_set(pending_q);
	assign cur_bit = NODE_W'(1) << cur;
	assign fresh   = rows_q[cur[ROW_W-1:0]] & mask_q & ~visited_q;

	assign stat.quick = (operation == OP_WRITE) || quick_err || (source_node == target_node);
	assign stat.hit   = (cur == dst_q);
	assign stat.empty = (pending_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				rows_q[i] <= '0;
			end
		end else if (cmd.accept && (operation == OP_WRITE) && src_in_rows) begin
			rows_q[source_node[ROW_W-1:0]] <= row_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			pending_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.quick_out || cmd.finish_hit || cmd.finish_miss;
			priority if (cmd.init) begin
				visited_q <= src_bit;
				pending_q <= src_bit;
			end else if (cmd.step) begin
				visited_q <= visited_q | fresh;
				pending_q <= (pending_q & ~cur_bit) | fresh;
			end else if (cmd.finish_hit || cmd.finish_miss) begin
				pending_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			dst_q  <= target_node;
			mask_q <= live_mask;
		end
		priority if (cmd.quick_out) begin
			reach_q <= quick_reach;
			err_q   <= quick_err;
		end else if (cmd.finish_hit) begin
			reach_q <= 1'b1;
			err_q   <= 1'b0;
		end else if (cmd.finish_miss) begin
			reach_q <= 1'b0;
			err_q   <= 1'b0;
		end
	end

	assign done        = done_q;
	assign reachable   = reach_q;
	assign index_error = err_q;

endmodule

// File: rtl/graph_reachability_query.sv
// Graph reachability query: top level with the APB register port, the controller and the datapath.
// A row write, an out-of-range query or a self query gives its word in the cycle after start is taken.
// A search query gives its word once the search ends in a hit or an empty pending set.
// The search expands each live node at most once, and the datapath expands one node per cycle.
// Results are strobed on done for one cycle and cannot be stalled; busy is high during a search.
// arst_n clears the adjacency rows and the search sets, and sets node_count to 32.
module graph_reachability_query
	import grq_pkg::*;
#(
	parameter int MAX_NODES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// Command channel. A word is taken at an edge where start is high and busy is low.
	input  logic              start,
	output logic              busy,
	input  logic              operation,
	input  logic [IDX_W-1:0]  source_node,
	input  logic [IDX_W-1:0]  target_node,
	input  logic [NODE_W-1:0] row_bits,
	// Result channel. One word per command, valid while done is high.
	output logic              done,
	output logic              reachable,
	output logic              index_error,
	// APB configuration port. The node_count register is at byte address zero.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(32);

	logic [CNT_W-1:0] node_count_q;
	logic             cfg_write;
	grq_cmd_t         cmd;
	grq_stat_t        stat;

	// The register is written in the access phase of an APB write. Writes with
	// paddr[2] set complete but change nothing.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
		end else if (cfg_write) begin
			node_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_NODE_COUNT) ? {{(32 - CNT_W){1'b0}}, node_count_q} : '0;

	// The controller sequences each command. Writes and trivial queries finish in the
	// accept cycle. A real query moves into the search state until a hit or an empty pending set.
	grq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the adjacency rows and the visited and pending sets, and it
	// registers every result word.
	grq_datapath #(
		.MAX_NODES (MAX_NODES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.node_count  (node_count_q),
		.operation   (operation),
		.source_node (source_node),
		.target_node (target_node),
		.row_bits    (row_bits),
		.done        (done),
		.reachable   (reachable),
		.index_error (index_error)
	);

endmodule

// File: tb/tb_graph_reachability_query.sv
// Self-checking testbench for graph_reachability_query: adjacency row writes, reachability queries
// and the node_count register. It depends on grq_pkg and the block itself, and nothing else.
// A scoreboard class predicts every result word and checks it against the done strobe.
module tb_graph_reachability_query
	import grq_pkg::*;
();

	localparam int         MAX_NODES       = 32;
	localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;
	// No word moves for at most the largest drawn gap plus a full search, so this limit is
	// many times the longest quiet stretch of a correct run.
	localparam int         IDLE_LIMIT      = 2000;
	// A search never takes longer than this settle time.
	localparam int         SETTLE_CYCLES   = 40;

	typedef enum int {GRAPH_SPARSE, GRAPH_DENSE, GRAPH_CHAIN} graph_shape_e;
	typedef enum int {GAPS_NONE, GAPS_FULL, GAPS_RARE} gap_style_e;

	typedef struct packed {
		logic reachable;
		logic index_error;
	} reach_word_t;

	// The scoreboard keeps its own copy of the adjacency rows and of node_count, and queues
	// the result word that each accepted command must produce.
	class reach_scoreboard;
		logic [NODE_W-1:0] adjacency [MAX_NODES];
		logic [CNT_W-1:0]  node_count;
		reach_word_t       expected_words [$];
		int                error_count;

		function new();
			foreach (adjacency[i]) adjacency[i] = '0;
			node_count  = CNT_W'(32);
			error_count = 0;
		endfunction

		// Values above the array size saturate, so 33 to 63 all behave like 32.
		function int live_count();
			return (node_count > MAX_NODES) ? MAX_NODES : int'(node_count);
		endfunction

		// Grows the set of nodes reachable from src until it stops changing. Edges to nodes
		// at or above the live count are masked off, exactly as the block ignores them.
		function logic [NODE_W-1:0] reach_set(int src, int n);
			logic [NODE_W-1:0] live;
			logic [NODE_W-1:0] seen;
			logic [NODE_W-1:0] grown;
			bit                growing;
			live = '0;
			for (int i = 0; i < n; i++) live[i] = 1'b1;
			seen      = '0;
			seen[src] = 1'b1;
			growing   = 1'b1;
			while (growing) begin
				grown = seen;
				for (int i = 0; i < MAX_NODES; i++) begin
					if (seen[i]) grown |= adjacency[i] & live;
				end
				growing = (grown != seen);
				seen    = grown;
			end
			return seen;
		endfunction

		function void note_command(logic op, logic [IDX_W-1:0] src, logic [IDX_W-1:0] dst,
				logic [NODE_W-1:0] row);
			reach_word_t       word;
			logic [NODE_W-1:0] seen;
			int                n;
			n    = live_count();
			word = '0;
			if (op == OP_WRITE) begin
				// The row is kept even when out of range, so a larger count can use it later.
				adjacency[src]    = row;
				word.index_error = (src >= n);
			end else if (src >= n || dst >= n) begin
				word.index_error = 1'b1;
			end else if (src == dst) begin
				word.reachable = 1'b1;
			end else begin
				seen           = reach_set(src, n);
				word.reachable = seen[dst];
			end
			expected_words = {expected_words, word};
		endfunction

		function void check_word(logic reach, logic err);
			reach_word_t word;
			if (expected_words.size() == 0) begin
				$display("%0t: result word with nothing expected, reachable %0b index_error %0b",
					$time, reach, err);
				error_count++;
				return;
			end
			word = expected_words.pop_front();
			if (reach !== word.reachable) begin
				$display("%0t: reachable mismatch, expected %0b, actual %0b",
					$time, word.reachable, reach);
				error_count++;
			end
			if (err !== word.index_error) begin
				$display("%0t: index_error mismatch, expected %0b, actual %0b",
					$time, word.index_error, err);
				error_count++;
			end
		endfunction
	endclass

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              start       = 1'b0;
	logic              busy;
	logic              operation   = OP_WRITE;
	logic [IDX_W-1:0]  source_node = '0;
	logic [IDX_W-1:0]  target_node = '0;
	logic [NODE_W-1:0] row_bits    = '0;
	logic              done;
	logic              reachable;
	logic              index_error;
	logic              psel        = 1'b0;
	logic              penable     = 1'b0;
	logic              pwrite      = 1'b0;
	logic [2:0]        paddr       = '0;
	logic [31:0]       pwdata      = '0;
	logic [31:0]       prdata;
	logic              pready;

	reach_scoreboard board;
	gap_style_e      gap_style   = GAPS_FULL;
	int              idle_cycles = 0;

	graph_reachability_query dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Monitor: everything is sampled at the rising edge, before the block's registers update.
	// The result word is checked before the new command is noted; a word accepted at this
	// edge cannot have its result at the same edge, so the order never matters.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) board.check_word(reachable, index_error);
			if (start && !busy) board.note_command(operation, source_node, target_node, row_bits);
			if (done || (start && !busy)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	function automatic int draw_gap();
		case (gap_style)
			GAPS_NONE: return 0;
			GAPS_FULL: return $urandom_range(0, 18);
			default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
		endcase
	endfunction

	// Start stays high from one command word to the next when no gap is drawn, so it never
	// gets two assignments in one time step.
	task automatic send_word(logic op, logic [IDX_W-1:0] src, logic [IDX_W-1:0] dst,
			logic [NODE_W-1:0] row);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		operation   <= op;
		source_node <= src;
		target_node <= dst;
		row_bits    <= row;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Holds off new commands until every expected result word has come back.
	task automatic wait_results();
		start <= 1'b0;
		@(posedge clk);
		while (board.expected_words.size() != 0) @(posedge clk);
	endtask

	// The block is idle here, so the register write and its read-back race with nothing.
	task automatic write_node_count(logic [CNT_W-1:0] value);
		wait_results();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_NODE_COUNT;
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(value)) begin
			$display("%0t: node_count read-back mismatch, expected %0h, actual %0h",
				$time, 32'(value), prdata);
			board.error_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		board.node_count = value;
	endtask

	// Builds one adjacency row. Sparse rows give irregular reachability, dense rows reach
	// almost everything, and chain rows link node i to node i+1 so that searches run long.
	// Bits beyond the live count are sprinkled in to check that the block ignores them.
	function automatic logic [NODE_W-1:0] make_row(graph_shape_e shape, int node, int n);
		logic [NODE_W-1:0] row;
		int                span;
		span = (n < 1) ? MAX_NODES : n;
		row  = '0;
		case (shape)
			GRAPH_SPARSE: begin
				repeat ($urandom_range(0, 2)) row[$urandom_range(0, span - 1)] = 1'b1;
				if ($urandom_range(0, 3) == 0) row[$urandom_range(0, MAX_NODES - 1)] = 1'b1;
			end
			GRAPH_DENSE: begin
				row = ($urandom_range(0, 1) != 0) ? $urandom : ($urandom & $urandom);
			end
			default: begin
				if (node + 1 < span) row[node + 1] = 1'b1;
				if ($urandom_range(0, 7) == 0) row[$urandom_range(0, span - 1)] = 1'b1;
				for (int i = span; i < MAX_NODES; i++) begin
					if ($urandom_range(0, 1) != 0) row[i] = 1'b1;
				end
			end
		endcase
		return row;
	endfunction

	// One phase: set node_count, load a graph of the given shape, then mostly in-range
	// queries and row rewrites, with some fully random words as noise.
	task automatic run_phase(logic [CNT_W-1:0] count_value, graph_shape_e shape, int items);
		int               n;
		int               sent;
		int               pick;
		logic [IDX_W-1:0] src;
		logic [IDX_W-1:0] dst;
		write_node_count(count_value);
		gap_style = gap_style_e'($urandom_range(0, 2));
		n    = board.live_count();
		sent = 0;
		if (n > 0) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				if (i < n || $urandom_range(0, 3) == 0) begin
					send_word(OP_WRITE, IDX_W'(i), IDX_W'($urandom), make_row(shape, i, n));
					sent++;
				end
			end
		end
		while (sent < items) begin
			pick = $urandom_range(0, 99);
			if (n == 0 || pick >= 92) begin
				send_word(logic'($urandom), IDX_W'($urandom), IDX_W'($urandom), $urandom);
			end else if (pick < 20) begin
				src = IDX_W'($urandom_range(0, n - 1));
				send_word(OP_WRITE, src, IDX_W'($urandom), make_row(shape, int'(src), n));
			end else begin
				src = IDX_W'($urandom_range(0, n - 1));
				dst = IDX_W'($urandom_range(0, n - 1));
				send_word(OP_QUERY, src, dst, $urandom);
			end
			if ($urandom_range(0, 99) == 0) wait_results();
			sent++;
		end
	endtask

	initial begin
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. After reset there are 32 nodes and no edges.
		gap_style = GAPS_FULL;
		send_word(OP_QUERY, 5'd0, 5'd31, 32'h0);
		send_word(OP_QUERY, 5'd7, 5'd7, 32'h0);
		send_word(OP_QUERY, 5'd31, 5'd31, 32'hFFFF_FFFF);
		send_word(OP_WRITE, 5'd0, 5'd0, 32'hFFFF_FFFF);
		send_word(OP_WRITE, 5'd31, 5'd31, 32'h0000_0001);
		send_word(OP_QUERY, 5'd0, 5'd31, 32'h0);
		send_word(OP_QUERY, 5'd31, 5'd0, 32'h0);
		send_word(OP_QUERY, 5'd30, 5'd0, 32'h0);
		// The sender stops here until all outstanding result words are back.
		wait_results();
		send_word(OP_WRITE, 5'd1, 5'd31, 32'h0000_0004);
		send_word(OP_WRITE, 5'd2, 5'd0, 32'h0000_0008);
		send_word(OP_QUERY, 5'd1, 5'd3, 32'h0);
		send_word(OP_QUERY, 5'd3, 5'd1, 32'h0);
		send_word(OP_WRITE, 5'd31, 5'd0, 32'h0);

		// A small graph: row 0 still reaches everything that remains live.
		write_node_count(6'd4);
		send_word(OP_QUERY, 5'd0, 5'd3, 32'h0);
		send_word(OP_QUERY, 5'd0, 5'd5, 32'h0);
		send_word(OP_QUERY, 5'd5, 5'd5, 32'h0);
		send_word(OP_WRITE, 5'd10, 5'd0, 32'h8000_0001);
		send_word(OP_QUERY, 5'd31, 5'd0, 32'h0);

		// With a count of zero every node index is out of range.
		write_node_count(6'd0);
		send_word(OP_QUERY, 5'd0, 5'd0, 32'h0);
		send_word(OP_WRITE, 5'd0, 5'd0, 32'hFFFF_FFFF);

		// The largest register value saturates to the full array; row 10 written above
		// while out of range must now be in effect.
		write_node_count(6'd63);
		send_word(OP_QUERY, 5'd0, 5'd31, 32'h0);
		send_word(OP_QUERY, 5'd10, 5'd0, 32'h0);

		write_node_count(6'd1);
		send_word(OP_QUERY, 5'd0, 5'd0, 32'h0);
		send_word(OP_QUERY, 5'd0, 5'd1, 32'h0);

		write_node_count(6'd32);
		send_word(OP_QUERY, 5'd2, 5'd1, 32'h0);

		// Random part: fixed settings for the extremes, then random counts and shapes.
		run_phase(6'd32, GRAPH_CHAIN, 70);
		run_phase(6'd32, GRAPH_SPARSE, 70);
		run_phase(6'd32, GRAPH_DENSE, 70);
		run_phase(6'd1, GRAPH_SPARSE, 40);
		run_phase(6'd2, GRAPH_CHAIN, 40);
		run_phase(6'd0, GRAPH_SPARSE, 20);
		run_phase(6'd63, GRAPH_CHAIN, 70);
		run_phase(6'd33, GRAPH_SPARSE, 70);
		run_phase(6'd17, GRAPH_CHAIN, 70);
		repeat (7) begin
			run_phase(CNT_W'($urandom_range(1, 32)), graph_shape_e'($urandom_range(0, 2)), 70);
		end

		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.error_count == 0 && board.expected_words.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: graph_reachability_query.f
rtl/grq_pkg.sv
rtl/grq_ctrl.sv
rtl/grq_datapath.sv
rtl/graph_reachability_query.sv
tb/tb_graph_reachability_query.sv
